@@ hdl/uf2bmc_pkg.sv @@
// ----------------------------------------------------------------------------
// uf2bmc_pkg
// Status codes, register map and fixed constants of the UF2 block merge checker.
// ----------------------------------------------------------------------------
package uf2bmc_pkg;

  typedef logic [3:0] status_t;
  typedef logic [2:0] reg_idx_t;

  localparam status_t ST_OK        = 4'd0;
  localparam status_t ST_MAGIC_A   = 4'd1;
  localparam status_t ST_MAGIC_B   = 4'd2;
  localparam status_t ST_MAGIC_END = 4'd3;
  localparam status_t ST_FLAGS     = 4'd4;
  localparam status_t ST_FAMILY    = 4'd5;
  localparam status_t ST_SIZE      = 4'd6;
  localparam status_t ST_ALIGN     = 4'd7;
  localparam status_t ST_RANGE     = 4'd8;
  localparam status_t ST_INDEX     = 4'd9;
  localparam status_t ST_COUNT     = 4'd10;
  localparam status_t ST_DUP       = 4'd11;
  localparam status_t ST_ORDER     = 4'd12;
  localparam status_t ST_SHORT     = 4'd13;

  localparam reg_idx_t REG_MAGIC_FIRST  = 3'd0;
  localparam reg_idx_t REG_MAGIC_SECOND = 3'd1;
  localparam reg_idx_t REG_MAGIC_FINAL  = 3'd2;
  localparam reg_idx_t REG_FLAGS        = 3'd3;
  localparam reg_idx_t REG_FAMILY       = 3'd4;
  localparam reg_idx_t REG_TOTAL_OUT    = 3'd5;

  localparam logic [31:0] RST_MAGIC_FIRST  = 32'd171066965;
  localparam logic [31:0] RST_MAGIC_SECOND = 32'd2657964375;
  localparam logic [31:0] RST_MAGIC_FINAL  = 32'd179400496;
  localparam logic [31:0] RST_FLAGS        = 32'd8192;
  localparam logic [31:0] RST_FAMILY       = 32'd3834380118;
  localparam logic [31:0] RST_TOTAL_OUT    = 32'd0;

  localparam logic [31:0] FLASH_ORIGIN = 32'h1000_0000;

  localparam int CFG_AW = 5;

endpackage

@@ hdl/uf2bmc_pagemap.sv @@
// ----------------------------------------------------------------------------
// uf2bmc_pagemap
// Page-usage bitmap, one byte per row, with a clearing sweep after reset and
// forwarding of a write that lands on the row being read.
// ----------------------------------------------------------------------------
module uf2bmc_pagemap #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  output logic          busy
);

  logic [7:0]    map_mem [DEPTH];
  logic [7:0]    rdata_r;
  logic [7:0]    fwd_data_r;
  logic          fwd_hit_r;
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;

  assign mem_we = clr_busy_r | wr_en;
  assign mem_wa = clr_busy_r ? clr_addr_r : wr_addr;
  assign mem_wd = clr_busy_r ? 8'd0 : wr_data;
  assign busy   = clr_busy_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rdata_r    <= map_mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r  <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      if (rd_en) begin
        fwd_hit_r <= wr_en && (wr_addr == rd_addr);
      end
      if (clr_busy_r) begin
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end else begin
          clr_addr_r <= clr_addr_r + AW'(1);
        end
      end
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : rdata_r;

endmodule

@@ hdl/uf2_block_merge_checker_top.sv @@
// ----------------------------------------------------------------------------
// uf2_block_merge_checker_top
// Checks UF2 block headers for a boot or application image, tracks page use
// and block order, and renumbers good blocks into the output image.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | content
//  in_     | in  | in_tvalid/in_tready   | one header request, or end of image
//  out_    | out | out_tvalid/out_tready | status and output block numbering
//  cfg_    | in  | APB, pready tied high | six 32-bit registers at 4*i
//
// One request per cycle while in_tready is high; the path from acceptance to
// out_tvalid runs through four stages and the output register, a depth set by
// the reciprocal multiply and the bitmap read-modify-write in the last stage.
// After reset the bitmap is swept to zero, one row a cycle: FLASH_BYTES /
// PAGE_BYTES / 8 rows, rounded up (8192 rows by default), with in_tready low.
// out_tready low holds the last stage; earlier stages keep closing bubbles.
// ----------------------------------------------------------------------------
module uf2_block_merge_checker_top import uf2bmc_pkg::*; #(
  parameter int FLASH_BYTES = 16777216,
  parameter int BOOT_BYTES  = 16384,
  parameter int PAGE_BYTES  = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // magic_start_a, magic_start_b, magic_end_word, flag_bits, family_field,
  // payload_bytes, target_address, block_index, block_total
  input  logic [287:0]      in_tdata,
  input  logic              in_tlast,   // action: end of image
  input  logic [0:0]        in_tuser,   // is_boot_image
  output logic              out_tvalid,
  input  logic              out_tready,
  // status[3:0], out_block_index[35:4], out_block_total[67:36], zero pad
  output logic [71:0]       out_tdata,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int PAGE_COUNT = FLASH_BYTES / PAGE_BYTES;
  localparam int MAP_BYTES  = (PAGE_COUNT + 7) / 8;
  localparam int MAW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int QW         = 33 - $clog2(PAGE_BYTES);
  localparam longint unsigned RECIP_L = 64'h1_0000_0000 / PAGE_BYTES;
  localparam logic [QW-1:0] RECIP     = QW'(RECIP_L);
  localparam logic [32:0] BOOT_LO  = 33'(FLASH_ORIGIN);
  localparam logic [32:0] APP_LO   = 33'(FLASH_ORIGIN) + 33'(BOOT_BYTES);
  localparam logic [32:0] BOOT_HI  = APP_LO;
  localparam logic [32:0] APP_HI   = 33'(FLASH_ORIGIN) + 33'(FLASH_BYTES);
  localparam logic [31:0] PAGE_W   = 32'(PAGE_BYTES);
  localparam logic [31:0] PCOUNT_W = 32'(PAGE_COUNT);
  localparam logic [31:0] PG_BASE  = 32'(FLASH_ORIGIN / PAGE_BYTES)
                                     + (((FLASH_ORIGIN % PAGE_BYTES) != 0) ? 32'd1 : 32'd0);

  // configuration
  logic [31:0] magic_first_r, magic_second_r, magic_final_r;
  logic [31:0] flags_exp_r, family_exp_r, total_out_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_first_r  <= RST_MAGIC_FIRST;
      magic_second_r <= RST_MAGIC_SECOND;
      magic_final_r  <= RST_MAGIC_FINAL;
      flags_exp_r    <= RST_FLAGS;
      family_exp_r   <= RST_FAMILY;
      total_out_r    <= RST_TOTAL_OUT;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_MAGIC_FIRST:  magic_first_r  <= cfg_pwdata;
        REG_MAGIC_SECOND: magic_second_r <= cfg_pwdata;
        REG_MAGIC_FINAL:  magic_final_r  <= cfg_pwdata;
        REG_FLAGS:        flags_exp_r    <= cfg_pwdata;
        REG_FAMILY:       family_exp_r   <= cfg_pwdata;
        REG_TOTAL_OUT:    total_out_r    <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_MAGIC_FIRST:  cfg_prdata = magic_first_r;
      REG_MAGIC_SECOND: cfg_prdata = magic_second_r;
      REG_MAGIC_FINAL:  cfg_prdata = magic_final_r;
      REG_FLAGS:        cfg_prdata = flags_exp_r;
      REG_FAMILY:       cfg_prdata = family_exp_r;
      REG_TOTAL_OUT:    cfg_prdata = total_out_r;
      default:          cfg_prdata = 32'd0;
    endcase
  end

  // pipeline flow
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_valid_r;
  logic out_free, s4_go, s4_free, s3_go, s3_free, s2_go, s2_free, s1_go, s1_free;
  logic in_go, clr_busy;

  assign out_free  = !out_valid_r || out_tready;
  assign s4_go     = s4_v_r && out_free;
  assign s4_free   = !s4_v_r || s4_go;
  assign s3_go     = s3_v_r && s4_free;
  assign s3_free   = !s3_v_r || s3_go;
  assign s2_go     = s2_v_r && s3_free;
  assign s2_free   = !s2_v_r || s2_go;
  assign s1_go     = s1_v_r && s2_free;
  assign s1_free   = !s1_v_r || s1_go;
  assign in_tready = !clr_busy && s1_free;
  assign in_go     = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free)  s1_v_r      <= in_go;
      if (s2_free)  s2_v_r      <= s1_go;
      if (s3_free)  s3_v_r      <= s2_go;
      if (s4_free)  s4_v_r      <= s3_go;
      if (out_free) out_valid_r <= s4_go;
    end
  end

  // stage 1: registered request
  logic        s1_end_r, s1_boot_r;
  logic [31:0] s1_ma_r, s1_mb_r, s1_me_r, s1_flags_r, s1_fam_r, s1_size_r;
  logic [31:0] s1_addr_r, s1_index_r, s1_total_r;

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_end_r   <= in_tlast;
      s1_boot_r  <= in_tuser[0];
      s1_ma_r    <= in_tdata[31:0];
      s1_mb_r    <= in_tdata[63:32];
      s1_me_r    <= in_tdata[95:64];
      s1_flags_r <= in_tdata[127:96];
      s1_fam_r   <= in_tdata[159:128];
      s1_size_r  <= in_tdata[191:160];
      s1_addr_r  <= in_tdata[223:192];
      s1_index_r <= in_tdata[255:224];
      s1_total_r <= in_tdata[287:256];
    end
  end

  status_t          s1_code;
  logic [32:0]      s1_lo, s1_hi;
  logic             s1_rng;
  logic [31+QW:0]   s1_prod;

  always_comb begin
    if (s1_ma_r != magic_first_r)       s1_code = ST_MAGIC_A;
    else if (s1_mb_r != magic_second_r) s1_code = ST_MAGIC_B;
    else if (s1_me_r != magic_final_r)  s1_code = ST_MAGIC_END;
    else if (s1_flags_r != flags_exp_r) s1_code = ST_FLAGS;
    else if (s1_fam_r != family_exp_r)  s1_code = ST_FAMILY;
    else if (s1_size_r != PAGE_W)       s1_code = ST_SIZE;
    else                                s1_code = ST_OK;
  end

  assign s1_lo   = s1_boot_r ? BOOT_LO : APP_LO;
  assign s1_hi   = s1_boot_r ? BOOT_HI : APP_HI;
  assign s1_rng  = ({1'b0, s1_addr_r} < s1_lo) || ({1'b0, s1_addr_r} + 33'(PAGE_W) > s1_hi);
  assign s1_prod = (32 + QW)'(s1_addr_r) * (32 + QW)'(RECIP);

  // stage 2: quotient estimate
  logic          s2_end_r, s2_rng_r, s2_idxf_r;
  status_t       s2_code_r;
  logic [QW-1:0] s2_q_r;
  logic [31:0]   s2_addr_r, s2_index_r, s2_total_r;

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_end_r   <= s1_end_r;
      s2_code_r  <= s1_code;
      s2_rng_r   <= s1_rng;
      s2_idxf_r  <= (s1_index_r >= s1_total_r);
      s2_q_r     <= s1_prod[31+QW:32];
      s2_addr_r  <= s1_addr_r;
      s2_index_r <= s1_index_r;
      s2_total_r <= s1_total_r;
    end
  end

  // stage 3: remainder before correction
  logic          s3_end_r, s3_rng_r, s3_idxf_r;
  status_t       s3_code_r;
  logic [QW-1:0] s3_q_r;
  logic [31:0]   s3_rem_r, s3_index_r, s3_total_r;

  always_ff @(posedge clk) begin
    if (s2_go) begin
      s3_end_r   <= s2_end_r;
      s3_code_r  <= s2_code_r;
      s3_rng_r   <= s2_rng_r;
      s3_idxf_r  <= s2_idxf_r;
      s3_q_r     <= s2_q_r;
      s3_rem_r   <= s2_addr_r - 32'(s2_q_r) * PAGE_W;
      s3_index_r <= s2_index_r;
      s3_total_r <= s2_total_r;
    end
  end

  logic          s3_big, s3_align;
  logic [QW-1:0] s3_q;
  logic [31:0]   s3_rem, s3_page;
  status_t       s3_code;

  assign s3_big   = (s3_rem_r >= PAGE_W);
  assign s3_q     = s3_q_r + QW'(s3_big);
  assign s3_rem   = s3_big ? (s3_rem_r - PAGE_W) : s3_rem_r;
  assign s3_align = (s3_rem == 32'd0);
  assign s3_page  = 32'(s3_q) - PG_BASE;

  always_comb begin
    if (s3_code_r != ST_OK)                     s3_code = s3_code_r;
    else if (!s3_align)                         s3_code = ST_ALIGN;
    else if (s3_rng_r || (s3_page >= PCOUNT_W)) s3_code = ST_RANGE;
    else if (s3_idxf_r)                         s3_code = ST_INDEX;
    else                                        s3_code = ST_OK;
  end

  // stage 4: bitmap read-modify-write and sequence state
  logic           s4_end_r;
  status_t        s4_code_r;
  logic [2:0]     s4_bit_r;
  logic [MAW-1:0] s4_row_r;
  logic [31:0]    s4_index_r, s4_total_r;

  always_ff @(posedge clk) begin
    if (s3_go) begin
      s4_end_r   <= s3_end_r;
      s4_code_r  <= s3_code;
      s4_bit_r   <= s3_page[2:0];
      s4_row_r   <= s3_page[3 +: MAW];
      s4_index_r <= s3_index_r;
      s4_total_r <= s3_total_r;
    end
  end

  logic [7:0]  map_rd, map_wd, bit_mask;
  logic        map_we;
  logic [31:0] next_seq_r, next_seq_nxt;
  logic [31:0] image_count_r, image_count_nxt;
  logic [31:0] out_count_r, out_count_nxt;
  logic [31:0] s4_oidx;
  status_t     s4_status;

  uf2bmc_pagemap #(
    .DEPTH (MAP_BYTES),
    .AW    (MAW)
  ) u_pagemap (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (s3_go),
    .rd_addr (s3_page[3 +: MAW]),
    .rd_data (map_rd),
    .wr_en   (map_we && s4_go),
    .wr_addr (s4_row_r),
    .wr_data (map_wd),
    .busy    (clr_busy)
  );

  assign bit_mask = 8'd1 << s4_bit_r;
  assign map_wd   = map_rd | bit_mask;

  always_comb begin
    next_seq_nxt    = next_seq_r;
    image_count_nxt = image_count_r;
    out_count_nxt   = out_count_r;
    s4_status       = ST_OK;
    s4_oidx         = 32'd0;
    map_we          = 1'b0;
    if (s4_end_r) begin
      s4_status       = (next_seq_r == image_count_r) ? ST_OK : ST_SHORT;
      next_seq_nxt    = 32'd0;
      image_count_nxt = 32'd0;
    end else if (s4_code_r != ST_OK) begin
      s4_status = s4_code_r;
    end else if ((next_seq_r != 32'd0) && (s4_total_r != image_count_r)) begin
      s4_status = ST_COUNT;
    end else begin
      if (next_seq_r == 32'd0) image_count_nxt = s4_total_r;
      if ((map_rd & bit_mask) != 8'd0) begin
        s4_status = ST_DUP;
      end else begin
        map_we = 1'b1;
        if (s4_index_r != next_seq_r) begin
          s4_status = ST_ORDER;
        end else begin
          next_seq_nxt  = next_seq_r + 32'd1;
          s4_oidx       = out_count_r;
          out_count_nxt = out_count_r + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_seq_r    <= 32'd0;
      image_count_r <= 32'd0;
      out_count_r   <= 32'd0;
    end else if (s4_go) begin
      next_seq_r    <= next_seq_nxt;
      image_count_r <= image_count_nxt;
      out_count_r   <= out_count_nxt;
    end
  end

  // output register
  status_t     out_status_r;
  logic [31:0] out_idx_r, out_total_r;

  always_ff @(posedge clk) begin
    if (s4_go) begin
      out_status_r <= s4_status;
      out_idx_r    <= s4_oidx;
      out_total_r  <= total_out_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_total_r, out_idx_r, out_status_r};

endmodule

@@ sim/tb_uf2_block_merge_checker_top.sv @@
// ----------------------------------------------------------------------------
// tb_uf2_block_merge_checker_top
// Drives UF2 header requests and end-of-image markers into the merge checker,
// predicts each status and renumbered block from a shadow of its registers,
// page bitmap and sequence state, and compares every result as it leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_uf2_block_merge_checker_top;
  import uf2bmc_pkg::*;

  localparam int FLASH_BYTES = 16777216;
  localparam int BOOT_BYTES  = 16384;
  localparam int PAGE_BYTES  = 256;
  localparam int PAGE_COUNT  = FLASH_BYTES / PAGE_BYTES;
  localparam int BOOT_PAGES  = BOOT_BYTES / PAGE_BYTES;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic        end_of_image;
    logic        boot;
    logic [31:0] magic_a;
    logic [31:0] magic_b;
    logic [31:0] end_magic;
    logic [31:0] flags;
    logic [31:0] family;
    logic [31:0] payload;
    logic [31:0] addr;
    logic [31:0] index;
    logic [31:0] total;
  } request_t;

  typedef struct {
    status_t     status;
    logic [31:0] renum_index;
    logic [31:0] block_total;
  } verdict_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [287:0]       in_tdata = '0;
  logic               in_tlast = 1'b0;
  logic [0:0]         in_tuser = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [71:0]        out_tdata;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]  cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  // register shadow
  logic [31:0] cfg_magic_a   = RST_MAGIC_FIRST;
  logic [31:0] cfg_magic_b   = RST_MAGIC_SECOND;
  logic [31:0] cfg_end_magic = RST_MAGIC_FINAL;
  logic [31:0] cfg_flags     = RST_FLAGS;
  logic [31:0] cfg_family    = RST_FAMILY;
  logic [31:0] cfg_total_out = RST_TOTAL_OUT;

  // image state shadow
  bit          page_taken [PAGE_COUNT];
  logic [31:0] seq_next = '0;
  logic [31:0] latched_total = '0;
  logic [31:0] blocks_issued = '0;

  verdict_t pending_verdicts [$];
  int       mismatches = 0;
  int       items_sent = 0;
  int       cycles = 0;
  int       stall_hold = 0;
  bit       sender_idles = 1'b1;
  bit       receiver_stalls = 1'b1;

  uf2_block_merge_checker_top #(
    .FLASH_BYTES(FLASH_BYTES),
    .BOOT_BYTES (BOOT_BYTES),
    .PAGE_BYTES (PAGE_BYTES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic verdict_t judge_request(input request_t r);
    verdict_t    v;
    logic [63:0] addr;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] page;
    v.status      = ST_OK;
    v.renum_index = '0;
    v.block_total = cfg_total_out;
    if (r.end_of_image) begin
      v.status      = (seq_next == latched_total) ? ST_OK : ST_SHORT;
      seq_next      = '0;
      latched_total = '0;
      return v;
    end
    addr = 64'(r.addr);
    lo   = r.boot ? 64'(FLASH_ORIGIN) : 64'(FLASH_ORIGIN) + BOOT_BYTES;
    hi   = r.boot ? 64'(FLASH_ORIGIN) + BOOT_BYTES : 64'(FLASH_ORIGIN) + FLASH_BYTES;
    if (r.magic_a != cfg_magic_a) v.status = ST_MAGIC_A;
    else if (r.magic_b != cfg_magic_b) v.status = ST_MAGIC_B;
    else if (r.end_magic != cfg_end_magic) v.status = ST_MAGIC_END;
    else if (r.flags != cfg_flags) v.status = ST_FLAGS;
    else if (r.family != cfg_family) v.status = ST_FAMILY;
    else if (r.payload != PAGE_BYTES) v.status = ST_SIZE;
    else if (addr % PAGE_BYTES != 0) v.status = ST_ALIGN;
    else if (addr < lo || addr + PAGE_BYTES > hi ||
             (addr - 64'(FLASH_ORIGIN)) / PAGE_BYTES >= PAGE_COUNT) v.status = ST_RANGE;
    else if (r.index >= r.total) v.status = ST_INDEX;
    else if (seq_next != 0 && r.total != latched_total) v.status = ST_COUNT;
    else begin
      if (seq_next == 0) latched_total = r.total;
      page = (addr - 64'(FLASH_ORIGIN)) / PAGE_BYTES;
      if (page_taken[int'(page)]) begin
        v.status = ST_DUP;
      end else begin
        page_taken[int'(page)] = 1'b1;
        if (r.index != seq_next) begin
          v.status = ST_ORDER;
        end else begin
          v.renum_index = blocks_issued;
          blocks_issued++;
          seq_next++;
        end
      end
    end
    return v;
  endfunction

  function automatic request_t make_block(input logic boot, input logic [31:0] idx,
                                          input logic [31:0] tot);
    request_t r;
    int       page;
    page = boot ? $urandom_range(0, BOOT_PAGES - 1) : $urandom_range(BOOT_PAGES, PAGE_COUNT - 1);
    r.end_of_image = 1'b0;
    r.boot         = boot;
    r.magic_a      = cfg_magic_a;
    r.magic_b      = cfg_magic_b;
    r.end_magic    = cfg_end_magic;
    r.flags        = cfg_flags;
    r.family       = cfg_family;
    r.payload      = PAGE_BYTES;
    r.addr         = FLASH_ORIGIN + page * PAGE_BYTES;
    r.index        = idx;
    r.total        = tot;
    return r;
  endfunction

  // header fields of an end marker are don't-care, so fill them with noise
  function automatic request_t noise_request(input logic end_of_image);
    request_t r;
    r.end_of_image = end_of_image;
    r.boot         = $urandom_range(0, 1);
    r.magic_a      = $urandom();
    r.magic_b      = $urandom();
    r.end_magic    = $urandom();
    r.flags        = $urandom();
    r.family       = $urandom();
    r.payload      = $urandom();
    r.addr         = $urandom();
    r.index        = $urandom();
    r.total        = $urandom();
    return r;
  endfunction

  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!sender_idles || roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_request(input request_t r);
    int gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tlast  <= r.end_of_image;
    in_tuser  <= r.boot;
    in_tdata  <= {r.total, r.index, r.addr, r.payload, r.family, r.flags,
                  r.end_magic, r.magic_b, r.magic_a};
    do @(posedge clk); while (!in_tready);
    pending_verdicts.push_back(judge_request(r));
    items_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // leaves psel high between back-to-back writes; the caller drops it after the last one
  task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_MAGIC_FIRST:  cfg_magic_a   = value;
      REG_MAGIC_SECOND: cfg_magic_b   = value;
      REG_MAGIC_FINAL:  cfg_end_magic = value;
      REG_FLAGS:        cfg_flags     = value;
      REG_FAMILY:       cfg_family    = value;
      REG_TOTAL_OUT:    cfg_total_out = value;
      default: ;
    endcase
  endtask

  task automatic program_registers(input logic [31:0] ma, input logic [31:0] mb,
                                   input logic [31:0] me, input logic [31:0] fl,
                                   input logic [31:0] fa, input logic [31:0] tot);
    drain_results();
    write_register(REG_MAGIC_FIRST, ma);
    write_register(REG_MAGIC_SECOND, mb);
    write_register(REG_MAGIC_FINAL, me);
    write_register(REG_FLAGS, fl);
    write_register(REG_FAMILY, fa);
    write_register(REG_TOTAL_OUT, tot);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic test_image_sequencing();
    request_t r;
    send_request(noise_request(1'b1));
    r = make_block(1'b1, 0, 3); r.addr = FLASH_ORIGIN;
    send_request(r);
    r = make_block(1'b1, 1, 3); r.addr = FLASH_ORIGIN;
    send_request(r);
    r = make_block(1'b1, 1, 4); r.addr = FLASH_ORIGIN + 32'h200;
    send_request(r);
    r = make_block(1'b1, 2, 3); r.addr = FLASH_ORIGIN + 32'h100;
    send_request(r);
    r = make_block(1'b1, 1, 3); r.addr = FLASH_ORIGIN + 32'h3F00;
    send_request(r);
    send_request(noise_request(1'b1));
    r = make_block(1'b0, 0, 32'hFFFF_FFFF); r.addr = FLASH_ORIGIN + 32'hFF_FF00;
    send_request(r);
    send_request(noise_request(1'b1));
  endtask

  task automatic test_header_faults();
    request_t r;
    int       i;
    for (i = 0; i < 10; i++) begin
      r = make_block(1'b0, 0, 1);
      case (i)
        0: r.magic_a   = ~r.magic_a;
        1: r.magic_b   = ~r.magic_b;
        2: r.end_magic = ~r.end_magic;
        3: r.flags     = ~r.flags;
        4: r.family    = ~r.family;
        5: r.payload   = 32'h0;
        6: r.payload   = 32'hFFFF_FFFF;
        7: r.addr      = r.addr + 1;
        8: begin r.index = 32'hFFFF_FFFF; r.total = 32'hFFFF_FFFF; end
        default: begin r.index = 32'h0; r.total = 32'h0; end
      endcase
      send_request(r);
    end
  endtask

  task automatic test_address_windows();
    request_t r;
    r = make_block(1'b1, 0, 1); r.addr = FLASH_ORIGIN + BOOT_BYTES;
    send_request(r);
    r = make_block(1'b0, 0, 1); r.addr = FLASH_ORIGIN + BOOT_BYTES - PAGE_BYTES;
    send_request(r);
    r = make_block(1'b0, 0, 1); r.addr = 32'h0;
    send_request(r);
    r = make_block(1'b0, 0, 1); r.addr = 32'hFFFF_FF00;
    send_request(r);
    r = make_block(1'b0, 0, 1); r.addr = FLASH_ORIGIN + FLASH_BYTES;
    send_request(r);
  endtask

  // mostly well-formed images with random content, some damaged blocks and noise
  task automatic test_random_images(input int goal);
    request_t    r;
    request_t    prev;
    int          stop_at;
    int          len;
    int          k;
    logic        boot;
    logic [31:0] flip;
    stop_at = items_sent + goal;
    prev    = make_block(1'b0, 0, 1);
    while (items_sent < stop_at) begin
      boot            = ($urandom_range(0, 3) == 0);
      len             = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
      sender_idles    = ($urandom_range(0, 5) != 0);
      receiver_stalls = ($urandom_range(0, 5) != 0);
      for (k = 0; k < len; k++) begin
        r = make_block(boot, k, len);
        if ($urandom_range(0, 99) < 15) begin
          flip = 32'd1 << $urandom_range(0, 31);
          case ($urandom_range(0, 10))
            0: r.magic_a   ^= flip;
            1: r.magic_b   ^= flip;
            2: r.end_magic ^= flip;
            3: r.flags     ^= flip;
            4: r.family    ^= flip;
            5: r.payload   ^= flip;
            6: r.total     = $urandom();
            7: r.index     = $urandom_range(0, len - 1);
            8: r.addr      = prev.addr;
            9: r.addr      ^= flip;
            default: r.boot = ~r.boot;
          endcase
        end
        send_request(r);
        prev = r;
        if ($urandom_range(0, 99) < 6)
          send_request(noise_request($urandom_range(0, 4) == 0));
      end
      if ($urandom_range(0, 9) != 0) send_request(noise_request(1'b1));
    end
  endtask

  task automatic test_register_extremes();
    program_registers(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
    test_random_images(420);
    program_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'h0);
    test_random_images(420);
  endtask

  task automatic test_random_registers();
    program_registers($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom());
    test_random_images(420);
  endtask

  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold--;
    end else if (!receiver_stalls) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 2) != 0);
      stall_hold = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin : result_monitor
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result with no request pending: out_tdata=%h", out_tdata);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tdata[3:0] !== want.status) begin
          $error("status mismatch: expected %0d actual %0d", want.status, out_tdata[3:0]);
          mismatches++;
        end
        if (out_tdata[35:4] !== want.renum_index) begin
          $error("out_block_index mismatch: expected %0d actual %0d", want.renum_index,
                 out_tdata[35:4]);
          mismatches++;
        end
        if (out_tdata[67:36] !== want.block_total) begin
          $error("out_block_total mismatch: expected %0d actual %0d", want.block_total,
                 out_tdata[67:36]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_image_sequencing();
    test_header_faults();
    test_address_windows();
    test_random_images(300);
    drain_results();
    test_random_images(160);
    test_register_extremes();
    test_random_registers();
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
